// ===== sv/itoa_pkg.sv =====
// Shared types and character constants for the integer-to-text radix converter.
`default_nettype none
package itoa_pkg;

  localparam int DIGIT_W = 6;   // one digit of a radix up to 36
  localparam int CHAR_W  = 7;   // ASCII code

  localparam logic [CHAR_W-1:0]  CH_MINUS      = 7'h2D;  // '-'
  localparam logic [CHAR_W-1:0]  CH_ZERO       = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CH_LETTER_GAP = 7'd7;   // 'A' - 10 - '0'
  localparam logic [DIGIT_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture a new word, sign and radix
    logic step;       // one restoring-division bit
    logic push;       // store the finished remainder digit
    logic emit_sign;  // send '-'
    logic pop;        // send the top digit
    logic pop_last;   // the popped digit ends the number
  } itoa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic neg;        // captured word is negative
    logic quo_zero;   // quotient of the last division is zero
    logic empty;      // digit stack holds nothing
    logic one_left;   // digit stack holds exactly one digit
    logic out_free;   // output register can take a character
  } itoa_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CH_ZERO + {1'b0, d};
    if (d >= DIGIT_TEN) c = c + CH_LETTER_GAP;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/integer_to_ascii_radix_unit.sv =====
// Top level of the integer-to-text radix converter.
// Operation: each digit of an accepted word comes from one pass of the restoring
//   divider; then the characters go out ('-' if negative, then the digits), each
//   waiting until the output register is free.
// One word at a time: the next is taken only once the last character of the
//   current one is loaded for output. The restoring divider makes one bit per cycle.
// Reset (rst, synchronous): returns to idle and empties the output register.
`default_nettype none
module integer_to_ascii_radix_unit #(
  parameter int WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [31:0] value,
  input  wire logic [5:0]  base,
  // output channel, one character per transfer
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       char_out,
  output logic             last
);

  itoa_pkg::itoa_cmd_t  ctl;
  itoa_pkg::itoa_stat_t st;

  // Controller: walks division rounds per digit, then sign and digits out.
  itoa_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (ctl)
  );

  // Datapath: digits come out of the divider least significant first and are
  // stacked so they leave most significant first.
  itoa_dp #(.WIDTH(WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl),
    .st        (st),
    .cmd_in    (cmd),
    .value     (value),
    .base      (base),
    .char_out  (char_out),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // A load happens exactly on an input transfer.
  a_load_on_transfer: assert property (@(posedge clk) disable iff (rst)
    ctl.load == (in_valid && !in_stall))
    else $error("load not aligned with input transfer");

  // Never pop an empty digit stack.
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !st.empty)
    else $error("pop from empty digit stack");

  // Once a word is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  // A character is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop || ctl.emit_sign) |-> (!out_valid || !out_stall))
    else $error("stalled character overwritten");

endmodule
`default_nettype wire

// ===== sv/itoa_ctrl.sv =====
// Sequencing state machine for the integer-to-text radix converter.
`default_nettype none
module itoa_ctrl #(
  parameter int WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire itoa_pkg::itoa_stat_t st,
  output itoa_pkg::itoa_cmd_t       cmd
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_PUSH = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   cnt, cnt_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(WIDTH - 1)) state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        cnt_next = '0;
        if (!st.quo_zero) state_next = S_DIV;
        else if (st.neg)  state_next = S_SIGN;
        else              state_next = S_EMIT;
      end
      S_SIGN: begin
        if (st.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.pop      = 1'b1;
          cmd.pop_last = st.one_left;
          if (st.one_left) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/itoa_dp.sv =====
// Datapath: bit-serial divider, digit stack and output register.
`default_nettype none
module itoa_dp #(
  parameter int WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire itoa_pkg::itoa_cmd_t  cmd,
  output itoa_pkg::itoa_stat_t      st,
  input  wire logic                 cmd_in,
  input  wire logic [31:0]          value,
  input  wire logic [5:0]           base,
  output logic [6:0]                char_out,
  output logic                      last,
  output logic                      out_valid,
  input  wire logic                 out_stall
);

  localparam int DW = itoa_pkg::DIGIT_W;
  localparam int SW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    radix;
  logic             neg;
  logic [DW-1:0]    stk [WIDTH];
  logic [SW-1:0]    depth;

  logic [WIDTH-1:0] mag_in;
  logic [DW-1:0]    radix_in;
  logic [DW:0]      shifted;
  logic             ge;
  logic [DW:0]      rem_wide;

  always_comb begin
    mag_in = WIDTH'(value);
    if (cmd_in && mag_in[WIDTH-1]) mag_in = '0 - mag_in;
    if (base < itoa_pkg::RADIX_MIN)      radix_in = itoa_pkg::RADIX_MIN;
    else if (base > itoa_pkg::RADIX_MAX) radix_in = itoa_pkg::RADIX_MAX;
    else                                 radix_in = base;
    shifted  = {rem, quo[WIDTH-1]};
    ge       = (shifted >= {1'b0, radix});
    rem_wide = ge ? (shifted - {1'b0, radix}) : shifted;
  end

  // divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo   <= mag_in;
      rem   <= '0;
      radix <= radix_in;
      neg   <= cmd_in && value[(WIDTH > 32) ? 0 : WIDTH-1] && (WIDTH <= 32);
    end else if (cmd.step) begin
      quo <= {quo[WIDTH-2:0], ge};
      rem <= rem_wide[DW-1:0];
    end else if (cmd.push) begin
      rem <= '0;
    end
  end

  // digit stack, top at entry 0
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk[0] <= rem;
      for (int i = 1; i < WIDTH; i++) stk[i] <= stk[i-1];
    end else if (cmd.pop) begin
      for (int i = 0; i < WIDTH - 1; i++) stk[i] <= stk[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           depth <= '0;
    else if (cmd.push) depth <= depth + 1'b1;
    else if (cmd.pop)  depth <= depth - 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_out <= itoa_pkg::CH_MINUS;
      last     <= 1'b0;
    end else if (cmd.pop) begin
      char_out <= itoa_pkg::digit_char(stk[0]);
      last     <= cmd.pop_last;
    end
  end

  always_comb begin
    st.neg      = neg;
    st.quo_zero = (quo == '0);
    st.empty    = (depth == '0);
    st.one_left = (depth == SW'(1));
    st.out_free = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// ===== bench/tb_integer_to_ascii_radix_unit.sv =====
// Self-checking testbench for the integer-to-text radix converter.
module tb_integer_to_ascii_radix_unit;

  localparam int WIDTH = 32;

  // Meaning of the cmd input.
  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;

  // Worst single word: base 2 with a sign, 33 characters, each digit costing
  // one divider pass.
  localparam int WORD_WORST   = (WIDTH + 1) * (WIDTH + 1) + 2;
  localparam int DRAIN_CYCLES = 2 * WORD_WORST;
  localparam int HOLD_CYCLES  = 3000;
  // About 500 words at worst-case cost, each character waiting out long
  // receiver stalls, plus the hold-off. Then taken a few times over.
  localparam int CYCLE_LIMIT  = 3_000_000;

  // One expected character of the output text.
  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] ch;
    logic                        is_last;
  } text_char_t;

  // One directed word. An empty string means the predictor supplies the text.
  typedef struct {
    logic        sgn;
    logic [31:0] word;
    logic [5:0]  radix;
    string       want;
  } word_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [31:0] value;
  logic [5:0]  base;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  char_out;
  logic        last;

  text_char_t pending_chars[$];   // characters still owed by the block, oldest first
  int send_idle_pct;
  int recv_idle_pct;
  logic hold_off_go;
  int fail_count    = 0;
  int words_sent    = 0;
  int neg_words     = 0;
  int chars_checked = 0;
  int cycle_count   = 0;

  integer_to_ascii_radix_unit #(.WIDTH(WIDTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .value     (value),
    .base      (base),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last      (last)
  );

  always #5 clk = ~clk;

  // Directed words: extremes of every field, both signedness modes, out-of-range
  // bases on both sides, zero, the most negative word and the longest text.
  word_row_t directed_rows[] = '{
    '{CMD_UNSIGNED, 32'h0000_0000, 6'd10, "0"},
    '{CMD_SIGNED,   32'h0000_0000, 6'd2,  "0"},
    '{CMD_UNSIGNED, 32'h0000_0001, 6'd2,  "1"},
    '{CMD_UNSIGNED, 32'hFFFF_FFFF, 6'd16, "FFFFFFFF"},
    '{CMD_UNSIGNED, 32'hFFFF_FFFF, 6'd10, "4294967295"},
    '{CMD_UNSIGNED, 32'hFFFF_FFFF, 6'd36, "1Z141Z3"},
    '{CMD_UNSIGNED, 32'hFFFF_FFFF, 6'd2,  ""},
    '{CMD_SIGNED,   32'hFFFF_FFFF, 6'd10, "-1"},
    '{CMD_SIGNED,   32'hFFFF_FFFF, 6'd0,  "-1"},
    '{CMD_SIGNED,   32'h8000_0000, 6'd10, "-2147483648"},
    '{CMD_SIGNED,   32'h8000_0000, 6'd2,  ""},
    '{CMD_UNSIGNED, 32'h8000_0000, 6'd16, "80000000"},
    '{CMD_UNSIGNED, 32'h8000_0000, 6'd2,  ""},
    '{CMD_SIGNED,   32'h7FFF_FFFF, 6'd10, "2147483647"},
    '{CMD_SIGNED,   32'h0000_0064, 6'd10, "100"},
    '{CMD_SIGNED,   32'hFFFF_FF9C, 6'd10, "-100"},
    '{CMD_UNSIGNED, 32'h0000_0023, 6'd36, "Z"},
    '{CMD_UNSIGNED, 32'h0000_000A, 6'd11, "A"},
    '{CMD_UNSIGNED, 32'h0000_0005, 6'd0,  "101"},
    '{CMD_UNSIGNED, 32'h0000_0005, 6'd1,  "101"},
    '{CMD_UNSIGNED, 32'h0000_0023, 6'd37, "Z"},
    '{CMD_UNSIGNED, 32'h0000_0024, 6'd63, "10"},
    '{CMD_SIGNED,   32'hDEAD_BEEF, 6'd7,  ""},
    '{CMD_UNSIGNED, 32'h1234_5678, 6'd13, ""}
  };

  // Expected text of one word: optional '-', then the magnitude's digits,
  // most significant first, minimal count. Pushed onto pending_chars.
  function automatic void predict_text(input logic sgn, input logic [31:0] word,
                                       input logic [5:0] radix);
    logic [63:0]                 mag;
    logic [63:0]                 r;
    logic [63:0]                 d;
    logic [itoa_pkg::CHAR_W-1:0] ch;
    logic                        neg;
    logic [5:0]                  digs[$];
    text_char_t                  tc;
    mag = {{(64-WIDTH){1'b0}}, word[WIDTH-1:0]};
    r = {58'd0, radix};
    if (r < 64'(itoa_pkg::RADIX_MIN)) r = 64'(itoa_pkg::RADIX_MIN);
    if (r > 64'(itoa_pkg::RADIX_MAX)) r = 64'(itoa_pkg::RADIX_MAX);
    neg = (sgn == CMD_SIGNED) && word[WIDTH-1];
    // 2's complement magnitude; the most negative word maps onto 2^(WIDTH-1)
    if (neg) mag = (64'd0 - mag) & ((64'd1 << WIDTH) - 64'd1);
    do begin
      d = mag % r;
      digs.push_front(d[5:0]);
      mag = mag / r;
    end while (mag != 64'd0);
    if (neg) begin
      tc.ch = itoa_pkg::CH_MINUS;
      tc.is_last = 1'b0;
      pending_chars.push_back(tc);
    end
    foreach (digs[i]) begin
      ch = itoa_pkg::CH_ZERO + {1'b0, digs[i]};
      if (digs[i] > 6'd9) ch = ch + itoa_pkg::CH_LETTER_GAP;
      tc.ch = ch;
      tc.is_last = (i == digs.size() - 1);
      pending_chars.push_back(tc);
    end
  endfunction

  // Offer one word, idling first at random; returns right after the transfer
  // edge with in_valid still high so back-to-back words need no dip.
  task automatic send_word(input logic sgn, input logic [31:0] word,
                           input logic [5:0] radix, input string want);
    text_char_t tc;
    byte        wc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= sgn;
    value    <= word;
    base     <= radix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge
    if (want.len() == 0) begin
      predict_text(sgn, word, radix);
    end else begin
      for (int i = 0; i < want.len(); i++) begin
        wc = want[i];
        tc.ch = wc[itoa_pkg::CHAR_W-1:0];
        tc.is_last = (i == want.len() - 1);
        pending_chars.push_back(tc);
      end
    end
    words_sent++;
    if (sgn == CMD_SIGNED && word[WIDTH-1]) neg_words++;
  endtask

  // Random word: mostly legal bases, a share clamped from either side; values
  // spread over full words, short words, small numbers, corners and powers of
  // the radix (and one below) so digit counts roll over.
  task automatic pick_word(output logic sgn, output logic [31:0] word,
                           output logic [5:0] radix);
    logic [63:0] r;
    logic [63:0] p;
    int          k;
    sgn = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       radix = 6'($urandom_range(1));
      1:       radix = 6'($urandom_range(63, 37));
      default: radix = 6'($urandom_range(36, 2));
    endcase
    r = 64'((radix < itoa_pkg::RADIX_MIN) ? itoa_pkg::RADIX_MIN :
            (radix > itoa_pkg::RADIX_MAX) ? itoa_pkg::RADIX_MAX : radix);
    case ($urandom_range(9))
      0, 1, 2, 3: word = $urandom;
      4, 5:       word = $urandom >> $urandom_range(31);
      6: begin
        word = $urandom_range(40);
        if ($urandom_range(1)) word = 32'd0 - word;
      end
      7: begin
        case ($urandom_range(4))
          0:       word = 32'h0000_0000;
          1:       word = 32'h0000_0001;
          2:       word = 32'h7FFF_FFFF;
          3:       word = 32'h8000_0000;
          default: word = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        p = 64'd1;
        k = int'($urandom_range(32, 1));
        repeat (k) if (p * r <= 64'hFFFF_FFFF) p = p * r;
        word = p[31:0] - $urandom_range(1);
        if ($urandom_range(1)) word = 32'd0 - word;
      end
    endcase
  endtask

  // Receiver: random stalls, plus one long hold-off counted here so the
  // block backs up and stalls its input while words keep coming.
  initial begin : receiver
    int held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Each character transfer is matched against the oldest expected one.
  always @(posedge clk) begin : check_text
    text_char_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $error("char_out: nothing expected, got 0x%02h (last=%0b)", char_out, last);
        fail_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (char_out !== exp_c.ch) begin
          $error("char_out: expected 0x%02h, got 0x%02h", exp_c.ch, char_out);
          fail_count++;
        end
        if (last !== exp_c.is_last) begin
          $error("last: expected %0b, got %0b", exp_c.is_last, last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic        sgn;
    logic [31:0] word;
    logic [5:0]  radix;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = CMD_UNSIGNED;
    value         = 32'd0;
    base          = 6'd0;
    hold_off_go   = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 54;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].sgn, directed_rows[i].word,
                directed_rows[i].radix, directed_rows[i].want);

    // Phase one: sender gaps light, receiver stalls heavy.
    for (int n = 0; n < 150; n++) begin
      pick_word(sgn, word, radix);
      send_word(sgn, word, radix, "");
    end

    // Phase two: the other way round.
    send_idle_pct = 54;
    recv_idle_pct = 31;
    for (int n = 0; n < 150; n++) begin
      pick_word(sgn, word, radix);
      send_word(sgn, word, radix, "");
    end

    // Phase three: full rate on both sides, with the long hold-off part way in.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 145; n++) begin
      if (n == 40) hold_off_go = 1'b1;
      pick_word(sgn, word, radix);
      send_word(sgn, word, radix, "");
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d words (%0d negative) and %0d checked characters,",
             words_sent, neg_words, chars_checked);
    $display("bases 0..63 with clamping, both signedness modes, and a backed-up output.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
